// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge once reset is released.
`define RNACK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rnack assertion failed");

// Check on every rising edge, reset included.
`define RNACK_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rnack assertion failed");

`endif

// ===== rtl/rnack_pkg.sv =====
// ----------------------------------------------------------------------------
// rnack_pkg
// Types and constants of the RTCP generic NACK lost-sequence expander.
// ----------------------------------------------------------------------------
package rnack_pkg;

    localparam logic [7:0]  NACK_PT       = 8'd205;
    localparam logic [4:0]  NACK_FMT      = 5'd1;
    localparam logic [1:0]  RTP_VERSION   = 2'd2;
    localparam logic [15:0] NACK_MIN_LEN  = 16'd16;
    localparam logic [15:0] NACK_HDR_LEN  = 16'd12;
    localparam logic [15:0] SSRC_FIRST    = 16'd8;
    localparam logic [15:0] BYTE_CNT_MAX  = 16'hFFFF;
    localparam logic [15:0] PT_BYTE_IDX   = 16'd1;

    localparam logic KIND_LOST   = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    // One packet byte with its framing tags.
    typedef struct packed {
        logic [7:0]  byte_value;
        logic        first_byte;
        logic [15:0] packet_len;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic        kind;
        logic [15:0] seq_num;
        logic [31:0] src_ssrc;
        logic        last_of_run;
    } out_item_t;

    // Work handed from the byte parser to the expander.
    typedef struct packed {
        logic        valid;
        logic        reject;
        logic [15:0] pid;
        logic [15:0] blp;
        logic [31:0] ssrc;
    } job_t;

endpackage

// ===== rtl/rtcp_nack_lost_sequence_expander_top.sv =====
// ----------------------------------------------------------------------------
// rtcp_nack_lost_sequence_expander_top
// Parses RTCP generic NACK packets byte by byte and lists lost sequences.
// ----------------------------------------------------------------------------
//  channel  | signals                            | payload
//  ---------+------------------------------------+---------------------------
//  bytes    | byte_valid, byte_stall, byte_data  | in_item_t (byte, tags)
//  results  | nack_valid, nack_stall, nack_data  | out_item_t (kind, seq)
//
// A byte that yields no result, or only a reject, is taken without a scan.
// A byte closing an FCI block loads the PID result, then the expander scans
// the BLP bits up to the highest set bit while the byte input is held.
// A stalled result holds the scan at the next set bit and holds the byte
// input until it is taken.
// Reset clears all packet state at once; no clearing pass follows it.
// ----------------------------------------------------------------------------
module rtcp_nack_lost_sequence_expander_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  rnack_pkg::in_item_t  byte_data,
    output logic                 nack_valid,
    input  logic                 nack_stall,
    output rnack_pkg::out_item_t nack_data
);
    import rnack_pkg::*;

    job_t job;
    logic busy;
    logic accept;

    // Take a request only when the expander can load its result now
    assign byte_stall = busy || (nack_valid && nack_stall);
    assign accept     = byte_valid && !byte_stall;

    rnack_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_data),
        .job    (job)
    );

    rnack_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .out_stall (nack_stall),
        .out_valid (nack_valid),
        .res_data  (nack_data),
        .busy      (busy)
    );

endmodule

// ===== rtl/rnack_parse.sv =====
// ----------------------------------------------------------------------------
// rnack_parse
// Byte parser: header checks, SSRC latch and FCI block assembly.
// ----------------------------------------------------------------------------
module rnack_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  rnack_pkg::in_item_t item,
    output rnack_pkg::job_t     job
);
    import rnack_pkg::*;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] length_reg, length_next;
    logic        dropped_reg, dropped_next;
    logic [31:0] ssrc_reg, ssrc_next;
    logic [23:0] block_reg, block_next;
    logic        hdr_bad;
    logic [15:0] idx;

    assign idx = byte_count_reg;

    // First-byte header checks; (len - 12) mod 4 equals len mod 4
    assign hdr_bad = (item.packet_len < NACK_MIN_LEN) || (item.packet_len[1:0] != 2'd0)
                     || (item.byte_value[7:6] != RTP_VERSION)
                     || (item.byte_value[4:0] != NACK_FMT);

    // Decode one accepted byte
    always_comb
    begin
        byte_count_next = byte_count_reg;
        length_next     = length_reg;
        dropped_next    = dropped_reg;
        ssrc_next       = ssrc_reg;
        block_next      = block_reg;
        job             = '0;
        job.pid         = block_reg[23:8];
        job.blp         = {block_reg[7:0], item.byte_value};
        job.ssrc        = ssrc_reg;
        if (accept)
        begin
            if (item.first_byte)
            begin
                byte_count_next = 16'd1;
                length_next     = item.packet_len;
                ssrc_next       = '0;
                block_next      = '0;
                dropped_next    = hdr_bad;
                job.valid       = hdr_bad;
                job.reject      = hdr_bad;
            end
            else if (!dropped_reg && (idx < length_reg))
            begin
                if (byte_count_reg != BYTE_CNT_MAX)
                begin
                    byte_count_next = byte_count_reg + 16'd1;
                end
                if (idx == PT_BYTE_IDX)
                begin
                    if (item.byte_value != NACK_PT)
                    begin
                        dropped_next = 1'b1;
                        job.valid    = 1'b1;
                        job.reject   = 1'b1;
                    end
                end
                else if (idx[15:2] == SSRC_FIRST[15:2])
                begin
                    ssrc_next = {ssrc_reg[23:0], item.byte_value};
                end
                else if (idx < NACK_HDR_LEN)
                begin
                    // fixed header bytes carry nothing we keep
                end
                else if (idx[1:0] != 2'd3)
                begin
                    block_next = {block_reg[15:0], item.byte_value};
                end
                else
                begin
                    block_next = '0;
                    job.valid  = 1'b1;
                end
            end
        end
    end

    // Hold packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            length_reg     <= '0;
            dropped_reg    <= 1'b1;
            ssrc_reg       <= '0;
            block_reg      <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            length_reg     <= length_next;
            dropped_reg    <= dropped_next;
            ssrc_reg       <= ssrc_next;
            block_reg      <= block_next;
        end
    end

endmodule

// ===== rtl/rnack_expand.sv =====
// ----------------------------------------------------------------------------
// rnack_expand
// Result sequencer: walks the BLP mask one bit a cycle (holding at a set bit
// while the output is stalled) with a shared incrementer and drives the output register.
// ----------------------------------------------------------------------------
module rnack_expand (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rnack_pkg::job_t      job,
    input  logic                 out_stall,
    output logic                 out_valid,
    output rnack_pkg::out_item_t res_data,
    output logic                 busy
);
    import rnack_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t      state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   res_data_reg, res_data_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] mask_reg, mask_next;
    logic [31:0] ssrc_reg, ssrc_next;
    logic [15:0] seq_sum;
    logic        slot_free;
    logic        rest_empty;

    // Shared incrementer: PID + i + 1 for bit i
    assign seq_sum    = seq_reg + 16'd1;
    assign slot_free  = !out_valid_reg || !out_stall;
    assign rest_empty = (mask_reg[15:1] == 15'd0);

    // Sequence results
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        res_data_next  = res_data_reg;
        seq_next       = seq_reg;
        mask_next      = mask_reg;
        ssrc_next      = ssrc_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (job.valid)
                begin
                    out_valid_next = 1'b1;
                    if (job.reject)
                    begin
                        res_data_next = '{kind: KIND_REJECT, seq_num: '0,
                                          src_ssrc: '0, last_of_run: 1'b1};
                    end
                    else
                    begin
                        res_data_next = '{kind: KIND_LOST, seq_num: job.pid,
                                          src_ssrc: job.ssrc,
                                          last_of_run: (job.blp == 16'd0)};
                        seq_next  = job.pid;
                        mask_next = job.blp;
                        ssrc_next = job.ssrc;
                        if (job.blp != 16'd0)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // advance on a clear bit, or on a set bit once the slot frees
                if (!mask_reg[0] || slot_free)
                begin
                    seq_next  = seq_sum;
                    mask_next = {1'b0, mask_reg[15:1]};
                    if (mask_reg[0])
                    begin
                        out_valid_next = 1'b1;
                        res_data_next  = '{kind: KIND_LOST, seq_num: seq_sum,
                                           src_ssrc: ssrc_reg,
                                           last_of_run: rest_empty};
                    end
                    if (rest_empty)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            res_data_reg  <= '0;
            seq_reg       <= '0;
            mask_reg      <= '0;
            ssrc_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            res_data_reg  <= res_data_next;
            seq_reg       <= seq_next;
            mask_reg      <= mask_next;
            ssrc_reg      <= ssrc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_data  = res_data_reg;
    assign busy      = (state_reg == ST_SCAN);

endmodule

// ===== rtl/rnack_checker.sv =====
// ----------------------------------------------------------------------------
// rnack_checker
// Port-level checks on the NACK expander, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rnack_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 byte_valid,
    input logic                 byte_stall,
    input rnack_pkg::in_item_t  byte_data,
    input logic                 nack_valid,
    input logic                 nack_stall,
    input rnack_pkg::out_item_t nack_data
);
    import rnack_pkg::*;

    // No result is shown while in reset
    `RNACK_ASSERT_ALWAYS(a_reset_quiet, clk, (!rst_n |-> !nack_valid))

    // A stalled result holds
    `RNACK_ASSERT(a_out_hold, clk, rst_n,
        (nack_valid && nack_stall |=> nack_valid && $stable(nack_data)))

    // A reject is a lone result with zero fields
    `RNACK_ASSERT(a_reject_form, clk, rst_n,
        (nack_valid && (nack_data.kind == KIND_REJECT) |-> nack_data.last_of_run
         && (nack_data.seq_num == 16'd0) && (nack_data.src_ssrc == 32'd0)))

    // A waiting result blocks new requests
    `RNACK_ASSERT(a_block_in, clk, rst_n, (nack_valid && nack_stall |-> byte_stall))

endmodule

bind rtcp_nack_lost_sequence_expander_top rnack_checker u_rnack_checker (.*);
